/* hdl/nce_pkg.sv */
package nce_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int PIX_W     = 8;
    localparam int POS_W     = 10;
    localparam int SIZE_W    = 11;
    localparam int THR_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

    localparam logic [THR_W-1:0]  THR_RESET  = 8'd100;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // what an accepted item does once it reaches the compare stage
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;

    // source of the pending mark of the row above
    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_MEM  = 2'd1;
    localparam logic [1:0] SEL_TAIL = 2'd2;

    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] pixel;
    } nce_in_t;

    typedef struct packed {
        logic             edge_mark;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             frame_last;
    } nce_out_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic             has_row;
        logic             row_end;
        logic             bank;
        logic [1:0]       pend_sel;
        logic             last;
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } nce_item_t;

    typedef struct packed {
        logic inc_self;
        logic inc_left;
        logic below_bright;
    } nce_cmp_t;

endpackage

/* hdl/neighbor_contrast_edge_marker.sv */
// Edge marker for a raster stream of 8-bit pixels. One item enters per clock
// when the result side keeps up; an accepted item is registered in the compare
// stage, and its result then in the output register. The rate is set by the
// read-modify-write of the line memory (pixels of the row above) and the mark
// memory (two banks of 1-bit marks, swapped at each row end), each with one
// read and one write port and write-to-read forwarding. For a row after the
// first, each pixel reports the final mark of the pixel above it; pixels of
// the first row report nothing. After the last row, send image_width drain
// items (command = 1) to read out the marks of the last row; the last of them
// carries frame_last. Pixels sent while the last row waits, and drains sent
// at any other time, are taken and dropped. Marks are tracked by a fill count,
// so no clearing pass runs after reset. Write configuration only while idle.
module neighbor_contrast_edge_marker #(
    parameter int MAX_WIDTH  = nce_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = nce_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  nce_pkg::nce_in_t               s_payload,
    output logic                           m_valid,
    input  logic                           m_ready,
    output nce_pkg::nce_out_t              m_payload,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nce_pkg::SIZE_W-1:0]     cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [nce_pkg::THR_W-1:0]  thr_reg;
    logic [nce_pkg::SIZE_W-1:0] width_reg;
    logic [nce_pkg::SIZE_W-1:0] height_reg;

    nce_pkg::nce_item_t        s0_item;
    logic [COL_W-1:0]          s0_col;
    logic [COL_W:0]            mark_raddr;

    logic                      s1_valid_reg;
    nce_pkg::nce_item_t        s1_item_reg;
    logic [COL_W-1:0]          s1_col_reg;
    logic [nce_pkg::PIX_W-1:0] left_px_reg;
    logic                      left_mark_reg;
    logic                      tail_reg;
    logic                      m_valid_reg;
    nce_pkg::nce_out_t         m_payload_reg;

    logic                      accept;
    logic                      s1_has_out, s1_adv, s1_fire, s1_pixel;
    logic                      line_we, mark_we;
    logic [nce_pkg::PIX_W-1:0] up_px;
    logic                      mark_rd;
    logic                      pend_mark;
    nce_pkg::nce_cmp_t         cmp;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= nce_pkg::THR_RESET;
            width_reg  <= nce_pkg::SIZE_RESET;
            height_reg <= nce_pkg::SIZE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                nce_pkg::CFG_THRESHOLD: thr_reg    <= cfg_data[nce_pkg::THR_W-1:0];
                nce_pkg::CFG_WIDTH:     width_reg  <= cfg_data;
                nce_pkg::CFG_HEIGHT:    height_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // handshake: stage 1 moves unless its result is blocked at the output
    assign s1_pixel   = (s1_item_reg.kind == nce_pkg::KIND_PIXEL);
    assign s1_has_out = (s1_item_reg.kind == nce_pkg::KIND_DRAIN) ||
                        (s1_pixel && s1_item_reg.has_row);
    assign s1_adv     = !s1_has_out || !m_valid_reg || m_ready;
    assign s1_fire    = s1_valid_reg && s1_adv;
    assign s_ready    = !s1_valid_reg || s1_adv;
    assign accept     = s_valid && s_ready;

    nce_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .in_item    (s_payload),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .item       (s0_item),
        .col        (s0_col),
        .mark_raddr (mark_raddr)
    );

    assign line_we = s1_fire && s1_pixel;
    assign mark_we = line_we && (s1_col_reg != '0);

    nce_fwd_ram #(
        .DATA_W (nce_pkg::PIX_W),
        .ADDR_W (COL_W)
    ) u_line_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (s0_col),
        .rd_data (up_px),
        .wr_en   (line_we),
        .wr_addr (s1_col_reg),
        .wr_data (s1_item_reg.pixel)
    );

    // the left neighbor's mark is final once this pixel has been compared
    nce_fwd_ram #(
        .DATA_W (1),
        .ADDR_W (COL_W + 1)
    ) u_mark_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (mark_raddr),
        .rd_data (mark_rd),
        .wr_en   (mark_we),
        .wr_addr ({s1_item_reg.bank, s1_col_reg - COL_W'(1)}),
        .wr_data (cmp.inc_left)
    );

    nce_compare u_compare (
        .thr       (thr_reg),
        .pixel     (s1_item_reg.pixel),
        .up_px     (up_px),
        .left_px   (left_px_reg),
        .left_mark (left_mark_reg),
        .has_row   (s1_item_reg.has_row),
        .col_nz    (s1_col_reg != '0),
        .cmp       (cmp)
    );

    always_comb begin
        case (s1_item_reg.pend_sel)
            nce_pkg::SEL_MEM:  pend_mark = mark_rd;
            nce_pkg::SEL_TAIL: pend_mark = tail_reg;
            default:           pend_mark = 1'b0;
        endcase
    end

    // stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s0_item;
            s1_col_reg  <= s0_col;
        end
        if (line_we) begin
            left_px_reg   <= s1_item_reg.pixel;
            left_mark_reg <= cmp.inc_self;
            if (s1_item_reg.row_end) begin
                tail_reg <= cmp.inc_self;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && s1_has_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_has_out) begin
            m_payload_reg.edge_mark  <= pend_mark || (s1_pixel && cmp.below_bright);
            m_payload_reg.pos_x      <= s1_item_reg.pos_x;
            m_payload_reg.pos_y      <= s1_item_reg.pos_y;
            m_payload_reg.frame_last <= s1_item_reg.last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("stalled compare stage lost its item");

endmodule

/* hdl/nce_fwd_ram.sv */
module nce_fwd_ram #(
    parameter int DATA_W = 1,
    parameter int ADDR_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem_reg [2**ADDR_W];
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_reg     <= mem_reg[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // a read that meets a write to the same entry returns the new data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : data_reg;

endmodule

/* hdl/nce_front.sv */
module nce_front #(
    parameter int MAX_WIDTH  = nce_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = nce_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  nce_pkg::nce_in_t              in_item,
    input  logic [nce_pkg::SIZE_W-1:0]    width_cfg,
    input  logic [nce_pkg::SIZE_W-1:0]    height_cfg,
    output nce_pkg::nce_item_t            item,
    output logic [$clog2(MAX_WIDTH)-1:0]  col,
    output logic [$clog2(MAX_WIDTH):0]    mark_raddr
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int FILL_W = $clog2(MAX_WIDTH + 1);
    localparam int WLIM_W = (nce_pkg::SIZE_W > FILL_W) ? nce_pkg::SIZE_W : FILL_W;
    localparam int HLIM_W = (nce_pkg::SIZE_W > $clog2(MAX_HEIGHT + 1)) ?
                            nce_pkg::SIZE_W : $clog2(MAX_HEIGHT + 1);
    localparam logic [WLIM_W-1:0] W_MAX = WLIM_W'(MAX_WIDTH);
    localparam logic [HLIM_W-1:0] H_MAX = HLIM_W'(MAX_HEIGHT);

    logic [COL_W-1:0]  col_reg,   col_next;
    logic [ROW_W-1:0]  row_reg,   row_next;
    logic [COL_W-1:0]  drain_reg, drain_next;
    logic              done_reg,  done_next;
    logic              bank_reg,  bank_next;
    logic [FILL_W-1:0] fill_reg,  fill_next;

    logic [WLIM_W-1:0] w_ext, w_use;
    logic [HLIM_W-1:0] h_ext, h_use;
    logic [COL_W-1:0]  idx;
    logic [FILL_W-1:0] idx_plus;
    logic              col_end;
    logic              row_last;
    logic [1:0]        kind;

    always_comb begin
        w_ext = WLIM_W'(width_cfg);
        h_ext = HLIM_W'(height_cfg);
        if (w_ext == '0) begin
            w_use = WLIM_W'(1);
        end else if (w_ext > W_MAX) begin
            w_use = W_MAX;
        end else begin
            w_use = w_ext;
        end
        if (h_ext == '0) begin
            h_use = HLIM_W'(1);
        end else if (h_ext > H_MAX) begin
            h_use = H_MAX;
        end else begin
            h_use = h_ext;
        end
    end

    assign idx      = in_item.command ? drain_reg : col_reg;
    assign idx_plus = FILL_W'(idx) + FILL_W'(1);
    assign col_end  = (WLIM_W'(idx) + WLIM_W'(1)) >= w_use;
    assign row_last = (HLIM_W'(row_reg) + HLIM_W'(1)) >= h_use;

    always_comb begin
        if (in_item.command) begin
            kind = done_reg ? nce_pkg::KIND_DRAIN : nce_pkg::KIND_NONE;
        end else begin
            kind = done_reg ? nce_pkg::KIND_NONE : nce_pkg::KIND_PIXEL;
        end
    end

    always_comb begin
        item.kind    = kind;
        item.has_row = (row_reg != '0);
        item.row_end = !in_item.command && col_end;
        item.last    = in_item.command && col_end;
        item.bank    = bank_reg;
        item.pixel   = in_item.pixel;
        item.pos_x   = nce_pkg::POS_W'(idx);
        item.pos_y   = in_item.command ? nce_pkg::POS_W'(row_reg)
                                       : nce_pkg::POS_W'(row_reg - ROW_W'(1));
        // marks below the fill count are in memory, the last one sits in a register
        if (idx_plus < fill_reg) begin
            item.pend_sel = nce_pkg::SEL_MEM;
        end else if (idx_plus == fill_reg) begin
            item.pend_sel = nce_pkg::SEL_TAIL;
        end else begin
            item.pend_sel = nce_pkg::SEL_ZERO;
        end
    end

    assign col        = idx;
    assign mark_raddr = {~bank_reg, idx};

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        done_next  = done_reg;
        bank_next  = bank_reg;
        fill_next  = fill_reg;
        if (accept) begin
            case (kind)
                nce_pkg::KIND_PIXEL: begin
                    if (col_end) begin
                        col_next  = '0;
                        bank_next = ~bank_reg;
                        fill_next = idx_plus;
                        if (row_last) begin
                            done_next  = 1'b1;
                            drain_next = '0;
                        end else begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end else begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
                nce_pkg::KIND_DRAIN: begin
                    if (col_end) begin
                        col_next   = '0;
                        row_next   = '0;
                        drain_next = '0;
                        done_next  = 1'b0;
                        bank_next  = 1'b0;
                        fill_next  = '0;
                    end else begin
                        drain_next = drain_reg + COL_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
            done_reg  <= 1'b0;
            bank_reg  <= 1'b0;
            fill_reg  <= '0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
            done_reg  <= done_next;
            bank_reg  <= bank_next;
            fill_reg  <= fill_next;
        end
    end

    a_done_col_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (col_reg == '0))
        else $error("column count not zero while the last row waits");

    a_drain_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (drain_reg != '0) |-> done_reg)
        else $error("drain index moved outside the drain phase");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && kind == nce_pkg::KIND_PIXEL && col_end) |=>
        (fill_reg == $past(idx_plus)) && (bank_reg != $past(bank_reg)))
        else $error("row end did not swap mark banks");

endmodule

/* hdl/nce_compare.sv */
module nce_compare (
    input  logic [nce_pkg::THR_W-1:0] thr,
    input  logic [nce_pkg::PIX_W-1:0] pixel,
    input  logic [nce_pkg::PIX_W-1:0] up_px,
    input  logic [nce_pkg::PIX_W-1:0] left_px,
    input  logic                      left_mark,
    input  logic                      has_row,
    input  logic                      col_nz,
    output nce_pkg::nce_cmp_t         cmp
);

    logic [nce_pkg::PIX_W-1:0] up_minus, px_minus_up, left_minus, px_minus_left;
    logic up_dark, up_bright, left_dark, left_bright, do_left;

    assign up_minus      = up_px - pixel;
    assign px_minus_up   = pixel - up_px;
    assign left_minus    = left_px - pixel;
    assign px_minus_left = pixel - left_px;

    assign up_dark     = has_row && (up_px > pixel) && (up_minus > thr);
    assign up_bright   = has_row && (pixel > up_px) && (px_minus_up > thr);
    // skip the left compare once this pixel is already marked
    assign do_left     = col_nz && !up_dark;
    assign left_dark   = do_left && (left_px > pixel) && (left_minus > thr);
    assign left_bright = do_left && (pixel > left_px) && (px_minus_left > thr);

    assign cmp.inc_self     = up_dark || left_dark;
    assign cmp.inc_left     = left_mark || left_bright;
    assign cmp.below_bright = up_bright;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_W        = nce_pkg::MAX_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_CYCLES = 400;

    typedef enum logic [1:0] {MODE_SINK_SLOW, MODE_SOURCE_SLOW, MODE_FULL_RATE} pace_t;
    typedef enum logic [1:0] {FROM_MODEL, TYPED_NONE, TYPED_MARK} expect_src_t;
    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t                     kind;
        logic [nce_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [nce_pkg::SIZE_W-1:0]    reg_val;
        nce_pkg::nce_in_t              item;
        expect_src_t                   src;
        nce_pkg::nce_out_t             mark;
    } script_row_t;

    localparam int SCRIPT_LEN = 31;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    nce_pkg::nce_in_t  s_payload = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    nce_pkg::nce_out_t m_payload;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [nce_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [nce_pkg::SIZE_W-1:0]    cfg_data = '0;

    pace_t             pace = MODE_SINK_SLOW;
    bit                stall_receiver = 1'b0;
    int                mismatches = 0;
    int                random_items = 0;
    int unsigned       cycle_count = 0;
    nce_pkg::nce_out_t expected_marks [$];

    // edge marker state: configuration, line of pixels, two rows of marks
    logic [nce_pkg::THR_W-1:0]  thr_setting = nce_pkg::THR_RESET;
    logic [nce_pkg::SIZE_W-1:0] width_setting = nce_pkg::SIZE_RESET;
    logic [nce_pkg::SIZE_W-1:0] height_setting = nce_pkg::SIZE_RESET;
    logic [nce_pkg::PIX_W-1:0]  line_pix [MAX_W];
    bit                         marks_above [MAX_W] = '{default: 1'b0};
    bit                         marks_row [MAX_W] = '{default: 1'b0};
    int                         col_idx = 0;
    int                         row_idx = 0;
    int                         drain_col = 0;
    bit                         frame_done = 1'b0;

    script_row_t opening_rows [SCRIPT_LEN] = '{
        // drain before any frame: dropped
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b1, 8'hFF}, TYPED_NONE, '0},
        '{ROW_CFG,  nce_pkg::CFG_WIDTH,     11'd3, '0, FROM_MODEL, '0},
        '{ROW_CFG,  nce_pkg::CFG_HEIGHT,    11'd2, '0, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'h00}, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'hFF}, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'h00}, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'hFF}, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'h00}, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'h80}, FROM_MODEL, '0},
        // pixel while the last row waits: dropped
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'h4D}, TYPED_NONE, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b1, 8'h00}, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b1, 8'h55}, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b1, 8'hAA}, FROM_MODEL, '0},
        // one drain too many
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b1, 8'h00}, TYPED_NONE, '0},
        // top threshold: no difference can exceed it
        '{ROW_CFG,  nce_pkg::CFG_THRESHOLD, 11'h0FF, '0, FROM_MODEL, '0},
        '{ROW_CFG,  nce_pkg::CFG_WIDTH,     11'd2, '0, FROM_MODEL, '0},
        '{ROW_CFG,  nce_pkg::CFG_HEIGHT,    11'd1, '0, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'h00}, TYPED_NONE, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'hFF}, TYPED_NONE, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b1, 8'h00}, TYPED_MARK,
          '{1'b0, 10'd0, 10'd0, 1'b0}},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b1, 8'hFF}, TYPED_MARK,
          '{1'b0, 10'd1, 10'd0, 1'b1}},
        // zero threshold, upper data bits set and ignored
        '{ROW_CFG,  nce_pkg::CFG_THRESHOLD, 11'h700, '0, FROM_MODEL, '0},
        '{ROW_CFG,  nce_pkg::CFG_WIDTH,     11'd1, '0, FROM_MODEL, '0},
        '{ROW_CFG,  nce_pkg::CFG_HEIGHT,    11'd3, '0, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'h0A}, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'h0B}, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'h0B}, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b1, 8'h00}, FROM_MODEL, '0},
        // single-pixel frame
        '{ROW_CFG,  nce_pkg::CFG_HEIGHT,    11'd1, '0, FROM_MODEL, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b0, 8'hA5}, TYPED_NONE, '0},
        '{ROW_ITEM, nce_pkg::CFG_THRESHOLD, 11'd0, '{1'b1, 8'h5A}, TYPED_MARK,
          '{1'b0, 10'd0, 10'd0, 1'b1}}
    };

    neighbor_contrast_edge_marker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bit mark_step(input nce_pkg::nce_in_t item,
                                     output nce_pkg::nce_out_t mark);
        int w, h, thr, c, r, px, up, left;
        bit last;
        mark = '0;
        w = int'(width_setting);
        h = int'(height_setting);
        thr = int'(thr_setting);
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        if (h < 1) h = 1;
        if (h > nce_pkg::MAX_HEIGHT_DEF) h = nce_pkg::MAX_HEIGHT_DEF;

        if (item.command) begin
            if (!frame_done || drain_col >= MAX_W) return 1'b0;
            last = (drain_col + 1 >= w);
            mark.edge_mark = marks_above[drain_col];
            mark.pos_x = drain_col[nce_pkg::POS_W-1:0];
            mark.pos_y = row_idx[nce_pkg::POS_W-1:0];
            mark.frame_last = last;
            if (last) begin
                marks_above = '{default: 1'b0};
                marks_row = '{default: 1'b0};
                col_idx = 0;
                row_idx = 0;
                drain_col = 0;
                frame_done = 1'b0;
            end else begin
                drain_col++;
            end
            return 1'b1;
        end

        if (frame_done) return 1'b0;
        c = col_idx;
        r = row_idx;
        px = int'(item.pixel);
        // upper compare first; it may mark the current pixel and skip the left one
        if (r > 0) begin
            up = int'(line_pix[c]);
            if (up - px > thr) marks_row[c] = 1'b1;
            else if (px - up > thr) marks_above[c] = 1'b1;
        end
        if (c > 0 && !marks_row[c]) begin
            left = int'(line_pix[c-1]);
            if (left - px > thr) marks_row[c] = 1'b1;
            else if (px - left > thr) marks_row[c-1] = 1'b1;
        end
        line_pix[c] = item.pixel;

        if (r > 0) begin
            mark.edge_mark = marks_above[c];
            mark.pos_x = c[nce_pkg::POS_W-1:0];
            mark.pos_y = r[nce_pkg::POS_W-1:0] - 1'b1;
        end

        if (c + 1 >= w) begin
            marks_above = marks_row;
            marks_row = '{default: 1'b0};
            col_idx = 0;
            if (r + 1 >= h) begin
                frame_done = 1'b1;
                drain_col = 0;
            end else begin
                row_idx = r + 1;
            end
        end else begin
            col_idx = c + 1;
        end
        return (r > 0);
    endfunction

    // payload and valid hold until the item is taken; valid drops only on a gap
    task automatic push_item(input nce_pkg::nce_in_t item, input expect_src_t src,
                             input nce_pkg::nce_out_t typed_mark);
        nce_pkg::nce_out_t mark;
        bit                got;
        while (pace != MODE_FULL_RATE &&
               $urandom_range(0, 99) < (pace == MODE_SINK_SLOW ? 28 : 62)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        got = mark_step(item, mark);
        case (src)
            FROM_MODEL: if (got) expected_marks.push_back(mark);
            TYPED_MARK: expected_marks.push_back(typed_mark);
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_marks.size() != 0) @(posedge aclk);
        // dropped items and first-row pixels leave nothing to wait for
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [nce_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nce_pkg::SIZE_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            nce_pkg::CFG_THRESHOLD: thr_setting = val[nce_pkg::THR_W-1:0];
            nce_pkg::CFG_WIDTH:     width_setting = val;
            nce_pkg::CFG_HEIGHT:    height_setting = val;
            default: ;
        endcase
    endtask

    task automatic run_frame(input bit noisy);
        int                        w, h, step;
        logic [nce_pkg::PIX_W-1:0] px;
        nce_pkg::nce_in_t          item;
        w = int'(width_setting);
        h = int'(height_setting);
        px = nce_pkg::PIX_W'($urandom_range(0, 255));
        for (int n = 0; n < w * h; n++) begin
            if (noisy && $urandom_range(0, 99) < 3) begin
                item.command = 1'b1;
                item.pixel = nce_pkg::PIX_W'($urandom_range(0, 255));
                push_item(item, FROM_MODEL, '0);
            end
            case ($urandom_range(0, 3))
                0: px = nce_pkg::PIX_W'($urandom_range(0, 255));
                1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: begin
                    step = int'(px) + int'($urandom_range(0, 320)) - 160;
                    px = nce_pkg::PIX_W'(step < 0 ? 0 : (step > 255 ? 255 : step));
                end
            endcase
            item.command = 1'b0;
            item.pixel = px;
            push_item(item, FROM_MODEL, '0);
            random_items++;
        end
        if (noisy && $urandom_range(0, 4) == 0) begin
            item.command = 1'b0;
            item.pixel = nce_pkg::PIX_W'($urandom_range(0, 255));
            push_item(item, FROM_MODEL, '0);
        end
        for (int d = 0; d < w; d++) begin
            item.command = 1'b1;
            item.pixel = nce_pkg::PIX_W'($urandom_range(0, 255));
            push_item(item, FROM_MODEL, '0);
            random_items++;
        end
    endtask

    always @(posedge aclk) begin
        int hold_cycles;
        if (stall_receiver) begin
            stall_receiver = 1'b0;
            hold_cycles = STALL_CYCLES;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            case (pace)
                MODE_SINK_SLOW:   m_ready <= ($urandom_range(0, 99) >= 62);
                MODE_SOURCE_SLOW: m_ready <= ($urandom_range(0, 99) >= 28);
                default:          m_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        nce_pkg::nce_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_marks.size() == 0) begin
                $error("unexpected item: mark %0d x %0d y %0d last %0d", m_payload.edge_mark,
                       m_payload.pos_x, m_payload.pos_y, m_payload.frame_last);
                mismatches++;
            end else begin
                want = expected_marks.pop_front();
                if (m_payload.edge_mark !== want.edge_mark) begin
                    $error("edge_mark expected %0d actual %0d", want.edge_mark,
                           m_payload.edge_mark);
                    mismatches++;
                end
                if (m_payload.pos_x !== want.pos_x) begin
                    $error("pos_x expected %0d actual %0d", want.pos_x, m_payload.pos_x);
                    mismatches++;
                end
                if (m_payload.pos_y !== want.pos_y) begin
                    $error("pos_y expected %0d actual %0d", want.pos_y, m_payload.pos_y);
                    mismatches++;
                end
                if (m_payload.frame_last !== want.frame_last) begin
                    $error("frame_last expected %0d actual %0d", want.frame_last,
                           m_payload.frame_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        script_row_t               row;
        logic [2:0]                spare_bits;
        logic [nce_pkg::THR_W-1:0] thr;
        int                        pick;
        bit                        stall_used;
        stall_used = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening_rows[i]) begin
            row = opening_rows[i];
            if (row.kind == ROW_CFG) write_reg(row.reg_idx, row.reg_val);
            else push_item(row.item, row.src, row.mark);
        end

        while (random_items < RANDOM_ITEMS) begin
            pace = random_items < RANDOM_ITEMS / 3 ? MODE_SINK_SLOW :
                   (random_items < 2 * RANDOM_ITEMS / 3 ? MODE_SOURCE_SLOW : MODE_FULL_RATE);
            if (!stall_used && random_items >= 100) begin
                // frame deep enough to back the block up while the sink holds off
                write_reg(nce_pkg::CFG_WIDTH, 11'd16);
                write_reg(nce_pkg::CFG_HEIGHT, 11'd4);
                stall_receiver = 1'b1;
                stall_used = 1'b1;
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    pick = int'($urandom_range(0, 9));
                    thr = pick == 0 ? 8'd0 :
                          (pick == 1 ? 8'd255 : nce_pkg::THR_W'($urandom_range(0, 255)));
                    spare_bits = 3'($urandom_range(0, 7));
                    write_reg(nce_pkg::CFG_THRESHOLD, {spare_bits, thr});
                end
                if ($urandom_range(0, 2) == 0)
                    write_reg(nce_pkg::CFG_WIDTH, $urandom_range(0, 9) == 0 ?
                              nce_pkg::SIZE_W'($urandom_range(13, 64)) :
                              nce_pkg::SIZE_W'($urandom_range(1, 12)));
                if ($urandom_range(0, 2) == 0)
                    write_reg(nce_pkg::CFG_HEIGHT, $urandom_range(0, 9) == 0 ?
                              nce_pkg::SIZE_W'($urandom_range(7, 20)) :
                              nce_pkg::SIZE_W'($urandom_range(1, 6)));
            end
            run_frame(1'b1);
        end

        // tallest column
        pace = MODE_FULL_RATE;
        write_reg(nce_pkg::CFG_WIDTH, 11'd1);
        write_reg(nce_pkg::CFG_HEIGHT, 11'd1024);
        run_frame(1'b0);

        wait_idle();
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
hdl/nce_pkg.sv
hdl/nce_fwd_ram.sv
hdl/nce_front.sv
hdl/nce_compare.sv
hdl/neighbor_contrast_edge_marker.sv
verif/testbench.sv
